[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the entity decoder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/xed_pkg.sv]
// ----------------------------------------------------------------------------
// xed_pkg
// types and character constants shared by the entity decoder modules
// ----------------------------------------------------------------------------
package xed_pkg;

  // characters
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_G = 8'h67;
  localparam logic [7:0] CH_LOW_L = 8'h6C;
  localparam logic [7:0] CH_LOW_M = 8'h6D;
  localparam logic [7:0] CH_LOW_O = 8'h6F;
  localparam logic [7:0] CH_LOW_P = 8'h70;
  localparam logic [7:0] CH_LOW_Q = 8'h71;
  localparam logic [7:0] CH_LOW_S = 8'h73;
  localparam logic [7:0] CH_LOW_T = 8'h74;
  localparam logic [7:0] CH_LOW_U = 8'h75;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] DEC_BASE = 8'd10;

  // result bytes per transaction, working buffer length, held letter depth and name table sizes
  localparam int MAX_OUT    = 5;
  localparam int BUF_LEN    = 6;
  localparam int HOLD_DEPTH = 4;
  localparam int NAME_COUNT = 5;
  localparam int NAME_MAX   = 5;

  // named entity table: amp, lt, gt, quot, apos
  localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5};
  localparam logic [7:0] NAME_TEXT [NAME_COUNT][NAME_MAX] = '{
    '{CH_LOW_A, CH_LOW_M, CH_LOW_P, CH_SEMI,  8'h00},
    '{CH_LOW_L, CH_LOW_T, CH_SEMI,  8'h00,    8'h00},
    '{CH_LOW_G, CH_LOW_T, CH_SEMI,  8'h00,    8'h00},
    '{CH_LOW_Q, CH_LOW_U, CH_LOW_O, CH_LOW_T, CH_SEMI},
    '{CH_LOW_A, CH_LOW_P, CH_LOW_O, CH_LOW_S, CH_SEMI}
  };
  localparam logic [7:0] NAME_VALUE [NAME_COUNT] = '{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS};

  // decoder phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NAMED,
    PH_NUM
  } phase_t;

  // one group of result bytes caused by one input transaction
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] data;
    logic [2:0]              count;
    logic                    done;
  } bundle_t;

  // front to queue write
  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } push_t;

  // front status
  typedef struct packed {
    logic idle;
    logic pend;
  } front_stat_t;

endpackage

[src/xed_if.sv]
// ----------------------------------------------------------------------------
// xed_if
// valid/ready channels for encoded input and decoded output bytes
// ----------------------------------------------------------------------------
interface xed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface xed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_byte, output run_last, output text_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input text_done,
                  output ready);
endinterface

[src/xed_front.sv]
// ----------------------------------------------------------------------------
// xed_front
// accepts one byte per cycle while the queue has room, tracks entity matching, builds result groups
// ----------------------------------------------------------------------------
module xed_front (
  input  logic                 clk,
  input  logic                 rst,
  xed_in_if.sink               encoded,
  input  logic                 push_ready,
  output xed_pkg::push_t       push,
  output xed_pkg::front_stat_t stat
);
  import xed_pkg::*;

  typedef struct packed {
    logic [BUF_LEN-1:0][7:0] data;
    logic [2:0]              cnt;
  } obuf_t;

  // append one byte to the working buffer
  function automatic obuf_t add(obuf_t ob, logic [7:0] x);
    obuf_t r;
    r = ob;
    if (r.cnt < 3'(BUF_LEN)) begin
      r.data[r.cnt] = x;
      r.cnt         = r.cnt + 3'd1;
    end
    return r;
  endfunction

  phase_t                phase, phase_next;
  logic [7:0]            held [HOLD_DEPTH];
  logic [2:0]            held_count, held_count_next;
  logic [NAME_COUNT-1:0] match_mask, match_mask_next;
  logic [7:0]            number_value, number_next;
  logic                  pend_valid, pend_valid_next;
  logic [7:0]            pend_byte, pend_byte_next;
  logic                  held_we;
  logic [NAME_COUNT-1:0] hit, complete;
  logic [7:0]            ent_value;
  logic                  fire, is_digit;
  logic [7:0]            num_mac;
  obuf_t                 ob;
  logic [7:0]            b;

  assign b        = encoded.in_byte;
  assign fire     = encoded.valid && encoded.ready;
  assign encoded.ready = push_ready;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign num_mac  = 8'(number_value * DEC_BASE) + (b - CH_ZERO);

  // candidate names that still match with this byte
  always_comb begin
    ent_value = '0;
    for (int i = 0; i < NAME_COUNT; i++) begin
      hit[i] = match_mask[i] && (held_count < NAME_LEN[i]) &&
               (NAME_TEXT[i][held_count] == b);
      complete[i] = hit[i] && ((held_count + 3'd1) == NAME_LEN[i]);
      if (complete[i]) ent_value = ent_value | NAME_VALUE[i];
    end
  end

  // next state and result bytes
  always_comb begin
    ob              = '0;
    phase_next      = phase;
    held_count_next = held_count;
    match_mask_next = match_mask;
    number_next     = number_value;
    pend_valid_next = pend_valid;
    pend_byte_next  = pend_byte;
    held_we         = 1'b0;
    if (fire) begin
      if (pend_valid) ob = add(ob, pend_byte);
      unique case (phase)
        PH_NUM: begin
          if (is_digit) begin
            number_next = num_mac;
          end else begin
            ob          = add(ob, number_value);
            phase_next  = PH_IDLE;
            number_next = '0;
          end
        end
        PH_NAMED: begin
          if ((held_count == 3'd0) && (b == CH_HASH)) begin
            phase_next  = PH_NUM;
            number_next = '0;
          end else if (|complete) begin
            ob              = add(ob, ent_value);
            phase_next      = PH_IDLE;
            held_count_next = '0;
          end else if ((|hit) && (held_count < 3'(HOLD_DEPTH))) begin
            held_we         = 1'b1;
            held_count_next = held_count + 3'd1;
            match_mask_next = hit;
          end else begin
            // failed match: ampersand, held letters, then the byte (a new '&' reopens)
            ob = add(ob, CH_AMP);
            for (int j = 0; j < HOLD_DEPTH; j++) begin
              if (3'(j) < held_count) ob = add(ob, held[j]);
            end
            held_count_next = '0;
            if (b == CH_AMP) begin
              phase_next      = PH_NAMED;
              match_mask_next = '1;
            end else begin
              phase_next = PH_IDLE;
              ob         = add(ob, b);
            end
          end
        end
        PH_IDLE: begin
          if (b == CH_AMP) begin
            phase_next      = PH_NAMED;
            held_count_next = '0;
            match_mask_next = '1;
          end else begin
            ob = add(ob, b);
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
      if (encoded.stream_end) begin
        // end of text: flush whatever entity is open, letter of this byte included
        if (phase_next == PH_NAMED) begin
          ob = add(ob, CH_AMP);
          for (int j = 0; j < HOLD_DEPTH; j++) begin
            if (3'(j) < held_count_next)
              ob = add(ob, (held_we && (held_count == 3'(j))) ? b : held[j]);
          end
        end else if (phase_next == PH_NUM) begin
          ob = add(ob, number_next);
        end
        phase_next      = PH_IDLE;
        held_count_next = '0;
        number_next     = '0;
        pend_valid_next = 1'b0;
      end else begin
        // sixth byte carries over to the next transaction
        pend_valid_next = (ob.cnt == 3'(BUF_LEN));
        pend_byte_next  = ob.data[BUF_LEN-1];
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      held_count   <= '0;
      match_mask   <= '1;
      number_value <= '0;
      pend_valid   <= 1'b0;
    end else begin
      phase        <= phase_next;
      held_count   <= held_count_next;
      match_mask   <= match_mask_next;
      number_value <= number_next;
      pend_valid   <= pend_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_byte <= pend_byte_next;
    if (held_we) held[held_count[1:0]] <= b;
  end

  // result group to the queue
  always_comb begin
    push.valid        = fire && (ob.cnt != 3'd0);
    push.bundle.data  = ob.data[MAX_OUT-1:0];
    push.bundle.count = (ob.cnt > 3'(MAX_OUT)) ? 3'(MAX_OUT) : ob.cnt;
    push.bundle.done  = encoded.stream_end;
  end

  assign stat.idle = (phase == PH_IDLE);
  assign stat.pend = pend_valid;

endmodule

[src/xed_queue.sv]
// ----------------------------------------------------------------------------
// xed_queue
// small register queue of result groups between front and back
// ----------------------------------------------------------------------------
module xed_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  xed_pkg::push_t   push,
  output logic             push_ready,
  output xed_pkg::bundle_t pop_bundle,
  output logic             pop_valid,
  input  logic             pop_ready
);
  import xed_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_bundle = store[rd_ptr];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      count <= count + CNT_W'(1);
      else if (!do_push && do_pop) count <= count - CNT_W'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= push.bundle;
  end

endmodule

[src/xed_back.sv]
// ----------------------------------------------------------------------------
// xed_back
// serializes result groups into one output byte per transaction
// ----------------------------------------------------------------------------
module xed_back (
  input  logic             clk,
  input  logic             rst,
  input  xed_pkg::bundle_t pop_bundle,
  input  logic             pop_valid,
  output logic             pop_ready,
  xed_out_if.source        decoded
);
  import xed_pkg::*;

  bundle_t    cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic       last_byte, take;

  assign last_byte = ((idx + 3'd1) == cur.count);
  assign take      = decoded.valid && decoded.ready;
  assign pop_ready = !cur_valid || (take && last_byte);

  // group valid and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop_ready) begin
      cur_valid <= pop_valid;
      idx       <= '0;
    end else if (take) begin
      idx <= idx + 3'd1;
    end
  end

  // group payload
  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) cur <= pop_bundle;
  end

  // output channel
  assign decoded.valid     = cur_valid;
  assign decoded.out_byte  = cur.data[idx];
  assign decoded.run_last  = last_byte;
  assign decoded.text_done = last_byte && cur.done;

endmodule

[src/xml_entity_decoder_unit.sv]
// ----------------------------------------------------------------------------
// xml_entity_decoder_unit
// streaming XML entity decoder: named entities and decimal character refs
// ----------------------------------------------------------------------------
//  channel   dir  payload                          accepted when
//  encoded   in   in_byte[8], stream_end           valid && ready
//  decoded   out  out_byte[8], run_last, text_done valid && ready
//
//  one input byte per cycle while the queue has room; each byte's 0..5 results go out at one per cycle
//  the front decides all results of a byte in the cycle it is accepted
//  encoded.ready drops only when the result queue (QUEUE_DEPTH groups) is full
//  a result passes the queue entry, then the back's group register; stalls on decoded back up
//  through the queue; synchronous reset, no clearing pass
`include "assert_macros.svh"

module xml_entity_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  xed_in_if.sink    encoded,
  xed_out_if.source decoded
);
  import xed_pkg::*;

  push_t       push;
  logic        push_ready;
  bundle_t     pop_bundle;
  logic        pop_valid;
  logic        pop_ready;
  front_stat_t front_stat;

  // accept and classify
  xed_front u_front (
    .clk        (clk),
    .rst        (rst),
    .encoded    (encoded),
    .push_ready (push_ready),
    .push       (push),
    .stat       (front_stat)
  );

  // result group queue
  xed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop_bundle (pop_bundle),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // emit bytes
  xed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_bundle (pop_bundle),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .decoded    (decoded)
  );

  // checks
  `ASSERT_IMPLIES(a_done_is_last, clk, rst, decoded.valid && decoded.text_done, decoded.run_last, "text_done without run_last")
  `ASSERT_IMPLIES(a_end_pushes, clk, rst, encoded.valid && encoded.ready && encoded.stream_end, push.valid, "final byte produced no result")
  `ASSERT_NEXT(a_end_idle, clk, rst, encoded.valid && encoded.ready && encoded.stream_end, front_stat.idle && !front_stat.pend, "front not idle after end of text")
  `ASSERT_IMPLIES(a_pend_idle, clk, rst, front_stat.pend, front_stat.idle, "deferred byte while entity open")

endmodule

[test/xml_entity_decoder_unit_tb.sv]
// ----------------------------------------------------------------------------
// xml_entity_decoder_unit_tb
// self-checking bench for the streaming entity decoder: texts of plain bytes,
// named and numeric entities, broken prefixes and noise go in one transaction
// per byte; a scoreboard predicts every decoded byte and checks it in order
// ----------------------------------------------------------------------------
module xml_entity_decoder_unit_tb;
  import xed_pkg::*;

  localparam int TEXT_ITEMS  = 420;
  localparam int CALM_ITEMS  = 360;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 20;

  // one expected decoded transaction
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } out_beat_t;

  // predicts decoded bytes and checks them against the output channel
  class entity_text_board;
    phase_t     phase;
    logic [7:0] held [HOLD_DEPTH];
    int         held_n;
    logic [7:0] num_val;
    bit         defer_ok;
    logic [7:0] defer_byte;
    logic [7:0] step_bytes [$];
    out_beat_t  due_beats [$];
    int         fail_count;

    function new();
      phase      = PH_IDLE;
      foreach (held[i]) held[i] = 8'h00;
      held_n     = 0;
      num_val    = 8'h00;
      defer_ok   = 1'b0;
      defer_byte = 8'h00;
      fail_count = 0;
    endfunction

    // ordinary text: an ampersand opens an entity, anything else passes
    function void plain_in(logic [7:0] b);
      if (b == CH_AMP) begin
        phase  = PH_NAMED;
        held_n = 0;
      end else begin
        step_bytes.push_back(b);
      end
    endfunction

    // one byte after the ampersand
    function void named_in(logic [7:0] b);
      int k;
      bit prefix;
      bit same;
      k      = held_n;
      prefix = 1'b0;
      if (k == 0 && b == CH_HASH) begin
        phase   = PH_NUM;
        num_val = 8'h00;
        return;
      end
      for (int i = 0; i < NAME_COUNT; i++) begin
        if (k >= NAME_LEN[i]) continue;
        same = 1'b1;
        for (int j = 0; j < k; j++)
          if (held[j] != NAME_TEXT[i][j]) same = 1'b0;
        if (!same || NAME_TEXT[i][k] != b) continue;
        if (k + 1 == NAME_LEN[i]) begin
          step_bytes.push_back(NAME_VALUE[i]);
          phase  = PH_IDLE;
          held_n = 0;
          return;
        end
        prefix = 1'b1;
      end
      if (prefix && k < HOLD_DEPTH) begin
        held[k] = b;
        held_n  = k + 1;
        return;
      end
      // failed match: ampersand and held letters go out as text
      step_bytes.push_back(CH_AMP);
      for (int j = 0; j < k; j++) step_bytes.push_back(held[j]);
      phase  = PH_IDLE;
      held_n = 0;
      plain_in(b);
    endfunction

    // accepted input transaction: work out its decoded bytes
    function void note_input(logic [7:0] b, logic fin);
      int n;
      out_beat_t beat;
      step_bytes.delete();
      if (defer_ok) begin
        step_bytes.push_back(defer_byte);
        defer_ok = 1'b0;
      end
      case (phase)
        PH_NUM: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            num_val = num_val * DEC_BASE + (b - CH_ZERO);
          end else begin
            step_bytes.push_back(num_val);
            phase   = PH_IDLE;
            num_val = 8'h00;
          end
        end
        PH_NAMED: begin
          named_in(b);
        end
        default: begin
          phase = PH_IDLE;
          plain_in(b);
        end
      endcase
      // end of text flushes whatever is open
      if (fin) begin
        if (phase == PH_NAMED) begin
          step_bytes.push_back(CH_AMP);
          for (int j = 0; j < held_n; j++) step_bytes.push_back(held[j]);
        end else if (phase == PH_NUM) begin
          step_bytes.push_back(num_val);
        end
        phase   = PH_IDLE;
        held_n  = 0;
        num_val = 8'h00;
      end else if (step_bytes.size() > MAX_OUT) begin
        defer_byte = step_bytes[MAX_OUT];
        defer_ok   = 1'b1;
      end
      n = (step_bytes.size() > MAX_OUT) ? MAX_OUT : step_bytes.size();
      for (int i = 0; i < n; i++) begin
        beat.data = step_bytes[i];
        beat.last = (i == n - 1);
        beat.done = (i == n - 1) && fin;
        due_beats.push_back(beat);
      end
    endfunction

    // accepted output transaction: compare with the oldest expectation
    function void check_result(logic [7:0] d, logic rl, logic td);
      out_beat_t want;
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected result out_byte=%h run_last=%b text_done=%b",
                 $time, d, rl, td);
        fail_count++;
        return;
      end
      want = due_beats.pop_front();
      if (want.data !== d) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.data, d);
        fail_count++;
      end
      if (want.last !== rl) begin
        $display("%0t: run_last expected %b actual %b", $time, want.last, rl);
        fail_count++;
      end
      if (want.done !== td) begin
        $display("%0t: text_done expected %b actual %b", $time, want.done, td);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  xed_in_if  enc_if ();
  xed_out_if dec_if ();

  xml_entity_decoder_unit uut (
    .clk     (clk),
    .rst     (rst),
    .encoded (enc_if),
    .decoded (dec_if)
  );

  entity_text_board text_board;
  logic [7:0]       text_q [$];
  bit               idle_on;
  int               items_sent;
  int               quiet_cycles;
  int               stall_left;

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // output side backpressure in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      dec_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      dec_if.ready <= 1'b0;
    end else begin
      dec_if.ready <= 1'b1;
    end
  end

  // sample both channels and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (enc_if.valid && enc_if.ready)
        text_board.note_input(enc_if.in_byte, enc_if.stream_end);
      if (dec_if.valid && dec_if.ready)
        text_board.check_result(dec_if.out_byte, dec_if.run_last, dec_if.text_done);
      if ((enc_if.valid && enc_if.ready) || (dec_if.valid && dec_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("xml_entity_decoder_unit verification failed");
        $finish;
      end
    end
  end

  // one input transaction, entered and left at a falling edge
  task automatic send_byte(logic [7:0] b, logic fin);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      enc_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    enc_if.valid      <= 1'b1;
    enc_if.in_byte    <= b;
    enc_if.stream_end <= fin;
    @(posedge clk);
    while (!(enc_if.valid && enc_if.ready)) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s, bit close);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], close && (i == s.len() - 1));
  endtask

  // append one random token of text
  function automatic void add_token();
    int kind;
    int sel;
    int cut;
    logic [7:0] noise [12];
    noise = '{CH_AMP, CH_HASH, CH_SEMI, CH_LOW_A, CH_LOW_G, CH_LOW_L,
              CH_LOW_M, CH_LOW_O, CH_LOW_P, CH_LOW_Q, CH_LOW_S, CH_LOW_T};
    kind = $urandom_range(0, 99);
    sel  = $urandom_range(0, NAME_COUNT - 1);
    if (kind < 30) begin
      // plain byte
      text_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 55) begin
      // complete named entity
      text_q.push_back(CH_AMP);
      for (int j = 0; j < NAME_LEN[sel]; j++) text_q.push_back(NAME_TEXT[sel][j]);
    end else if (kind < 70) begin
      // numeric entity with a random terminator
      text_q.push_back(CH_AMP);
      text_q.push_back(CH_HASH);
      repeat ($urandom_range(0, 4)) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      text_q.push_back(($urandom_range(0, 3) != 0) ? CH_SEMI : 8'($urandom_range(0, 255)));
    end else if (kind < 85) begin
      // broken named prefix
      cut = $urandom_range(0, NAME_LEN[sel] - 1);
      text_q.push_back(CH_AMP);
      for (int j = 0; j < cut; j++) text_q.push_back(NAME_TEXT[sel][j]);
      case ($urandom_range(0, 3))
        0:       text_q.push_back(CH_AMP);
        1:       text_q.push_back(CH_HASH);
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end else begin
      // noise from the entity alphabet
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 4) == 0)
          text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        else
          text_q.push_back(noise[$urandom_range(0, 11)]);
      end
    end
  endfunction

  // main sequence
  initial begin
    text_board        = new();
    rst               = 1'b1;
    enc_if.valid      = 1'b0;
    enc_if.in_byte    = 8'h00;
    enc_if.stream_end = 1'b0;
    dec_if.ready      = 1'b0;
    idle_on           = 1'b1;
    items_sent        = 0;
    quiet_cycles      = 0;
    stall_left        = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed texts: entities, deferred sixth byte, '#' after letters,
    // numeric without digits, wrapped number open at end, dropped sixth byte
    send_text("&amp;&gt;", 1'b0);
    send_text("&quotx", 1'b0);
    send_text("&a#", 1'b0);
    send_text("&#;", 1'b0);
    send_text("&#300", 1'b1);
    send_text("&aposz", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // random texts, some cut short inside a token
    while (items_sent < TEXT_ITEMS) begin
      text_q.delete();
      repeat ($urandom_range(1, 6)) add_token();
      if ($urandom_range(0, 4) == 0)
        while (text_q.size() > 1 && $urandom_range(0, 1) == 0) void'(text_q.pop_back());
      foreach (text_q[i]) begin
        if (items_sent >= CALM_ITEMS) idle_on = 1'b0;
        send_byte(text_q[i], i == text_q.size() - 1);
      end
    end
    enc_if.valid <= 1'b0;

    // drain and catch stray results
    while (text_board.due_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (text_board.due_beats.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               text_board.due_beats.size());
      text_board.fail_count++;
    end
    if (text_board.fail_count == 0) begin
      $display("xml_entity_decoder_unit verification clean");
    end else begin
      $display("xml_entity_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
